@@ hw/rtl/skc_pkg.sv @@
// Shared constants, types and saturating helpers for the scalar Kalman smoother.
`timescale 1ns / 1ps
package skc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned MaxSteps = 1024;
  localparam int unsigned AddrW    = $clog2(MaxSteps);
  localparam int unsigned CountW   = AddrW + 1;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned StepW    = 4;
  localparam int unsigned MulCntW  = $clog2(DataW);
  localparam int unsigned DivSteps = 2 * FracW + 1;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  typedef logic signed [DataW-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(DataW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DataW-1){1'b0}}};
  localparam word_t WordOne = word_t'(1) <<< FracW;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_INIT_VAR   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OBS_OFFSET = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STATE_NVAR = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRANSITION = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INTERCEPT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NOISE_LOAD = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OBS_LOAD   = 3'd6;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SMOOTH = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_BUSY  = 2'd3;

  // Sequence steps: last step of each item kind, and the reciprocal slot
  localparam logic [StepW-1:0] LOAD_LAST   = 4'd15;
  localparam logic [StepW-1:0] SMOOTH_LAST = 4'd13;
  localparam logic [StepW-1:0] RECIP_STEP  = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ISSUE,
    ST_WAIT,
    ST_STORE,
    ST_RESULT
  } skc_state_e;

  // Saturating sum
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      sat_add = s[DataW] ? WordMin : WordMax;
    end else begin
      sat_add = s[DataW-1:0];
    end
  endfunction

  // Saturating difference
  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      sat_sub = s[DataW] ? WordMin : WordMax;
    end else begin
      sat_sub = s[DataW-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/skc_mul.sv @@
// Bit-serial fixed-point multiplier with rounding and saturation.
`timescale 1ns / 1ps
module skc_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  skc_pkg::word_t      a_i,
  input  skc_pkg::word_t      b_i,
  output logic                done_o,
  output skc_pkg::word_t      p_o
);

  logic                          busy_q, fin_q, neg_q;
  logic [skc_pkg::MulCntW-1:0]   cnt_q;
  logic [2*skc_pkg::DataW-1:0]   prod_q;
  logic [skc_pkg::DataW-1:0]     mcand_q;
  logic [skc_pkg::DataW:0]       sum;
  logic [2*skc_pkg::DataW-1:0]   rnd;
  logic                          over;
  logic [skc_pkg::DataW-1:0]     mag_q;

  // Add the multiplicand into the top half when the low bit is set
  assign sum = {1'b0, prod_q[2*skc_pkg::DataW-1:skc_pkg::DataW]}
             + (prod_q[0] ? {1'b0, mcand_q} : '0);

  // Round half away from zero on the magnitude, then saturate
  assign rnd  = prod_q + ((2*skc_pkg::DataW)'(1) << (skc_pkg::FracW - 1));
  assign over = |rnd[2*skc_pkg::DataW-1:skc_pkg::FracW+skc_pkg::DataW-1];
  assign mag_q = rnd[skc_pkg::FracW+skc_pkg::DataW-1:skc_pkg::FracW];

  always_comb begin
    if (!neg_q) begin
      p_o = over ? skc_pkg::WordMax : mag_q;
    end else begin
      p_o = over ? skc_pkg::WordMin : -mag_q;
    end
  end

  assign done_o = fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == skc_pkg::MulCntW'(skc_pkg::DataW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // Load magnitudes, then shift one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i[skc_pkg::DataW-1] ? -a_i : a_i;
      prod_q  <= {{skc_pkg::DataW{1'b0}}, (b_i[skc_pkg::DataW-1] ? -b_i : b_i)};
      neg_q   <= a_i[skc_pkg::DataW-1] ^ b_i[skc_pkg::DataW-1];
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[skc_pkg::DataW-1:1]};
    end
  end

endmodule

@@ hw/rtl/skc_recip.sv @@
// Bit-serial restoring divider that forms a saturated fixed-point reciprocal.
`timescale 1ns / 1ps
module skc_recip (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  skc_pkg::word_t      d_i,
  output logic                done_o,
  output skc_pkg::word_t      q_o
);

  logic                          busy_q, fin_q, neg_q, zero_q;
  logic [skc_pkg::DivCntW-1:0]   cnt_q;
  logic [skc_pkg::DataW-1:0]     dmag_q;
  logic [skc_pkg::DataW:0]       rem_q, quo_q, sh;
  logic                          fits;
  logic                          over;

  // Shift in the dividend bit: a single one at the top
  assign sh   = {rem_q[skc_pkg::DataW-1:0], (cnt_q == '0)};
  assign fits = (sh >= {1'b0, dmag_q});
  assign over = |quo_q[skc_pkg::DataW:skc_pkg::DataW-1];

  always_comb begin
    if (zero_q) begin
      q_o = skc_pkg::WordMax;
    end else if (!neg_q) begin
      q_o = over ? skc_pkg::WordMax : quo_q[skc_pkg::DataW-1:0];
    end else begin
      q_o = over ? skc_pkg::WordMin : -quo_q[skc_pkg::DataW-1:0];
    end
  end

  assign done_o = fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == skc_pkg::DivCntW'(skc_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dmag_q <= d_i[skc_pkg::DataW-1] ? -d_i : d_i;
      neg_q  <= d_i[skc_pkg::DataW-1];
      zero_q <= (d_i == '0);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (sh - {1'b0, dmag_q}) : sh;
      quo_q <= {quo_q[skc_pkg::DataW-1:0], fits};
    end
  end

endmodule

@@ hw/rtl/scalar_kalman_disturbance_smoother_top.sv @@
// Top level: sequencer, state, step stores and result register of the smoother.
//
// channel  direction  handshake                 words
// in       slave      in_valid_i / in_ready_o   kind, observation, noise_variance
// out      master     out_valid_o / out_ready_i ten result fields
// cfg      slave      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A load runs 16 sequence steps: 15 bit-serial multiplies (issue, shifts, done) and one
// bit-serial reciprocal, then a store write; its result is registered once the result
// register is free, and the next word may be taken as the sequencer returns to idle.
// A smooth runs one store read and 14 multiplies before its result is registered.
// A rejected word goes straight to the result state and runs no sequence steps.
// Reset clears control state, configuration and running state; the stores need no clearing.
// A new word is taken once the sequencer is idle, even while a result waits.
`timescale 1ns / 1ps
module scalar_kalman_disturbance_smoother_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [skc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [skc_pkg::DataW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic signed [31:0]            observation_i,
  input  logic signed [31:0]            noise_variance_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            smoothed_signal_o,
  output logic signed [31:0]            smoothed_variance_o,
  output logic signed [31:0]            innovation_o,
  output logic signed [31:0]            inverse_innovation_variance_o,
  output logic signed [31:0]            filter_gain_o,
  output logic signed [31:0]            state_factor_o,
  output logic signed [31:0]            obs_disturbance_o,
  output logic [9:0]                    time_index_o,
  output logic                          last_o,
  output logic [1:0]                    status_o
);

  skc_pkg::skc_state_e state_q, state_d;

  // Configuration registers
  skc_pkg::word_t init_var_q, obs_off_q, snv_q, tc_q, ic_q, g_q, z_q;

  // Datapath registers
  skc_pkg::word_t pm_q, pv_q, ys_q, hs_q, nu_q, finv_q, k_q, l_q, f_q;
  skc_pkg::word_t t_q, acc_q, v_q, eps_q, sig_q, r_q, n_q;

  logic [skc_pkg::CountW-1:0] count_q;
  logic                       phase_q;
  logic                       kind_q;
  logic [1:0]                 status_q;
  logic [skc_pkg::StepW-1:0]  step_q;
  logic                       out_valid_q;

  // Step stores
  skc_pkg::word_t obs_mem   [skc_pkg::MaxSteps];
  skc_pkg::word_t noise_mem [skc_pkg::MaxSteps];
  skc_pkg::word_t innov_mem [skc_pkg::MaxSteps];
  skc_pkg::word_t finv_mem  [skc_pkg::MaxSteps];
  skc_pkg::word_t gain_mem  [skc_pkg::MaxSteps];
  skc_pkg::word_t fact_mem  [skc_pkg::MaxSteps];

  logic [skc_pkg::AddrW-1:0]  wr_addr, rd_addr;
  logic [skc_pkg::CountW-1:0] count_dec;

  skc_pkg::word_t op_a, op_b, res;
  logic           is_div, mul_start, div_start, mul_done, div_done, step_done;
  logic           is_last_step, accept, out_free;
  skc_pkg::word_t mul_p, div_q;

  assign count_dec = count_q - 1'b1;
  assign wr_addr   = count_q[skc_pkg::AddrW-1:0];
  assign rd_addr   = count_dec[skc_pkg::AddrW-1:0];

  assign in_ready_o  = (state_q == skc_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign is_div       = (kind_q == skc_pkg::KIND_LOAD) && (step_q == skc_pkg::RECIP_STEP);
  assign mul_start    = (state_q == skc_pkg::ST_ISSUE) && !is_div;
  assign div_start    = (state_q == skc_pkg::ST_ISSUE) && is_div;
  assign step_done    = mul_done || div_done;
  assign res          = is_div ? div_q : mul_p;
  assign is_last_step = (kind_q == skc_pkg::KIND_LOAD) ? (step_q == skc_pkg::LOAD_LAST)
                                                       : (step_q == skc_pkg::SMOOTH_LAST);

  // Select multiplier operands for each step of the sequence
  always_comb begin
    op_a = t_q;
    op_b = t_q;
    if (kind_q == skc_pkg::KIND_LOAD) begin
      unique case (step_q)
        4'd0:    begin op_a = z_q;  op_b = z_q;    end
        4'd1:    begin op_a = t_q;  op_b = pv_q;   end
        4'd2:    begin op_a = z_q;  op_b = pm_q;   end
        4'd3:    begin op_a = f_q;  op_b = f_q;    end
        4'd4:    begin op_a = tc_q; op_b = pv_q;   end
        4'd5:    begin op_a = t_q;  op_b = z_q;    end
        4'd6:    begin op_a = t_q;  op_b = finv_q; end
        4'd7:    begin op_a = k_q;  op_b = z_q;    end
        4'd8:    begin op_a = tc_q; op_b = pm_q;   end
        4'd9:    begin op_a = k_q;  op_b = nu_q;   end
        4'd10:   begin op_a = tc_q; op_b = tc_q;   end
        4'd11:   begin op_a = t_q;  op_b = pv_q;   end
        4'd12:   begin op_a = g_q;  op_b = g_q;    end
        4'd13:   begin op_a = t_q;  op_b = snv_q;  end
        4'd14:   begin op_a = k_q;  op_b = k_q;    end
        default: begin op_a = t_q;  op_b = f_q;    end
      endcase
    end else begin
      unique case (step_q)
        4'd0:    begin op_a = k_q;  op_b = n_q;    end
        4'd1:    begin op_a = t_q;  op_b = k_q;    end
        4'd2:    begin op_a = hs_q; op_b = acc_q;  end
        4'd3:    begin op_a = t_q;  op_b = hs_q;   end
        4'd4:    begin op_a = nu_q; op_b = finv_q; end
        4'd5:    begin op_a = k_q;  op_b = r_q;    end
        4'd6:    begin op_a = hs_q; op_b = acc_q;  end
        4'd7:    begin op_a = z_q;  op_b = nu_q;   end
        4'd8:    begin op_a = t_q;  op_b = finv_q; end
        4'd9:    begin op_a = l_q;  op_b = r_q;    end
        4'd10:   begin op_a = z_q;  op_b = z_q;    end
        4'd11:   begin op_a = t_q;  op_b = finv_q; end
        4'd12:   begin op_a = l_q;  op_b = n_q;    end
        default: begin op_a = t_q;  op_b = l_q;    end
      endcase
    end
  end

  skc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  skc_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .d_i     (op_a),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skc_pkg::ST_IDLE: begin
        if (accept) begin
          if (kind_i == skc_pkg::KIND_LOAD) begin
            if (phase_q || count_q >= skc_pkg::CountW'(skc_pkg::MaxSteps)) begin
              state_d = skc_pkg::ST_RESULT;
            end else begin
              state_d = skc_pkg::ST_ISSUE;
            end
          end else if (count_q == '0) begin
            state_d = skc_pkg::ST_RESULT;
          end else begin
            state_d = skc_pkg::ST_READ;
          end
        end
      end
      skc_pkg::ST_READ:  state_d = skc_pkg::ST_ISSUE;
      skc_pkg::ST_ISSUE: state_d = skc_pkg::ST_WAIT;
      skc_pkg::ST_WAIT: begin
        if (step_done) begin
          if (!is_last_step) begin
            state_d = skc_pkg::ST_ISSUE;
          end else if (kind_q == skc_pkg::KIND_LOAD) begin
            state_d = skc_pkg::ST_STORE;
          end else begin
            state_d = skc_pkg::ST_RESULT;
          end
        end
      end
      skc_pkg::ST_STORE: state_d = skc_pkg::ST_RESULT;
      skc_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = skc_pkg::ST_IDLE;
        end
      end
      default: state_d = skc_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skc_pkg::ST_IDLE;
      count_q     <= '0;
      phase_q     <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= skc_pkg::KIND_LOAD;
      status_q    <= skc_pkg::STATUS_OK;
      init_var_q  <= skc_pkg::WordOne;
      obs_off_q   <= '0;
      snv_q       <= skc_pkg::WordOne;
      tc_q        <= skc_pkg::WordOne;
      ic_q        <= '0;
      g_q         <= skc_pkg::WordOne;
      z_q         <= skc_pkg::WordOne;
      pm_q        <= '0;
      pv_q        <= '0;
      r_q         <= '0;
      n_q         <= '0;
    end else begin
      state_q <= state_d;

      // Write configuration; unknown indexes drop
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          skc_pkg::CFG_INIT_VAR:   init_var_q <= cfg_data_i;
          skc_pkg::CFG_OBS_OFFSET: obs_off_q  <= cfg_data_i;
          skc_pkg::CFG_STATE_NVAR: snv_q      <= cfg_data_i;
          skc_pkg::CFG_TRANSITION: tc_q       <= cfg_data_i;
          skc_pkg::CFG_INTERCEPT:  ic_q       <= cfg_data_i;
          skc_pkg::CFG_NOISE_LOAD: g_q        <= cfg_data_i;
          skc_pkg::CFG_OBS_LOAD:   z_q        <= cfg_data_i;
          default: ;
        endcase
      end

      // Take a word and classify it
      if (accept) begin
        kind_q <= kind_i;
        step_q <= '0;
        if (kind_i == skc_pkg::KIND_LOAD) begin
          if (phase_q) begin
            status_q <= skc_pkg::STATUS_BUSY;
          end else if (count_q >= skc_pkg::CountW'(skc_pkg::MaxSteps)) begin
            status_q <= skc_pkg::STATUS_FULL;
          end else begin
            status_q <= skc_pkg::STATUS_OK;
            if (count_q == '0) begin
              pm_q <= '0;
              pv_q <= init_var_q;
            end
          end
        end else if (count_q == '0) begin
          status_q <= skc_pkg::STATUS_EMPTY;
        end else begin
          status_q <= skc_pkg::STATUS_OK;
          if (!phase_q) begin
            phase_q <= 1'b1;
            r_q     <= '0;
            n_q     <= '0;
          end
        end
      end

      // Advance the sequence and update the running state
      if (state_q == skc_pkg::ST_WAIT && step_done) begin
        step_q <= step_q + 1'b1;
        if (kind_q == skc_pkg::KIND_LOAD) begin
          if (step_q == 4'd9) begin
            pm_q <= skc_pkg::sat_add(acc_q, res);
          end
          if (step_q == 4'd15) begin
            pv_q <= skc_pkg::sat_sub(acc_q, res);
          end
        end else begin
          if (step_q == 4'd9) begin
            r_q <= skc_pkg::sat_add(acc_q, res);
          end
          if (step_q == 4'd13) begin
            n_q <= skc_pkg::sat_add(acc_q, res);
          end
        end
      end

      // Deliver the result and retire the item; drop valid once the word is taken
      if (state_q == skc_pkg::ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
        if (status_q == skc_pkg::STATUS_OK) begin
          if (kind_q == skc_pkg::KIND_LOAD) begin
            count_q <= count_q + 1'b1;
          end else begin
            count_q <= count_dec;
            if (count_q == skc_pkg::CountW'(1)) begin
              phase_q <= 1'b0;
            end
          end
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ys_q <= observation_i;
      hs_q <= noise_variance_i;
    end

    // Registered store read for a smooth
    if (state_q == skc_pkg::ST_READ) begin
      ys_q   <= obs_mem[rd_addr];
      hs_q   <= noise_mem[rd_addr];
      nu_q   <= innov_mem[rd_addr];
      finv_q <= finv_mem[rd_addr];
      k_q    <= gain_mem[rd_addr];
      l_q    <= fact_mem[rd_addr];
    end

    if (state_q == skc_pkg::ST_WAIT && step_done) begin
      if (kind_q == skc_pkg::KIND_LOAD) begin
        unique case (step_q)
          4'd1:  f_q    <= skc_pkg::sat_add(res, hs_q);
          4'd2:  nu_q   <= skc_pkg::sat_sub(skc_pkg::sat_sub(ys_q, obs_off_q), res);
          4'd3:  finv_q <= res;
          4'd6:  k_q    <= res;
          4'd7:  l_q    <= skc_pkg::sat_sub(tc_q, res);
          4'd8:  acc_q  <= skc_pkg::sat_add(ic_q, res);
          4'd11: acc_q  <= res;
          4'd13: acc_q  <= skc_pkg::sat_add(acc_q, res);
          4'd9, 4'd15: ;
          default: t_q  <= res;
        endcase
      end else begin
        unique case (step_q)
          4'd1:  acc_q <= skc_pkg::sat_add(finv_q, res);
          4'd3:  v_q   <= skc_pkg::sat_sub(hs_q, res);
          4'd4:  acc_q <= res;
          4'd5:  acc_q <= skc_pkg::sat_sub(acc_q, res);
          4'd6: begin
            eps_q <= res;
            sig_q <= skc_pkg::sat_sub(ys_q, res);
          end
          4'd8, 4'd11: acc_q <= res;
          4'd9, 4'd13: ;
          default: t_q <= res;
        endcase
      end
    end

    // Fill the result register
    if (state_q == skc_pkg::ST_RESULT && out_free) begin
      status_o <= status_q;
      if (status_q == skc_pkg::STATUS_OK) begin
        innovation_o                  <= nu_q;
        inverse_innovation_variance_o <= finv_q;
        filter_gain_o                 <= k_q;
        state_factor_o                <= l_q;
        if (kind_q == skc_pkg::KIND_LOAD) begin
          time_index_o        <= count_q[skc_pkg::IdxW-1:0];
          smoothed_signal_o   <= '0;
          smoothed_variance_o <= '0;
          obs_disturbance_o   <= '0;
          last_o              <= 1'b0;
        end else begin
          time_index_o        <= count_dec[skc_pkg::IdxW-1:0];
          smoothed_signal_o   <= sig_q;
          smoothed_variance_o <= v_q;
          obs_disturbance_o   <= eps_q;
          last_o              <= (count_q == skc_pkg::CountW'(1));
        end
      end else begin
        smoothed_signal_o             <= '0;
        smoothed_variance_o           <= '0;
        obs_disturbance_o             <= '0;
        last_o                        <= 1'b0;
        innovation_o                  <= '0;
        inverse_innovation_variance_o <= '0;
        filter_gain_o                 <= '0;
        state_factor_o                <= '0;
        time_index_o                  <= '0;
      end
    end
  end

  // Step stores: one write per load that passes its checks
  always_ff @(posedge clk_i) begin
    if (state_q == skc_pkg::ST_STORE) begin
      obs_mem[wr_addr]   <= ys_q;
      noise_mem[wr_addr] <= hs_q;
      innov_mem[wr_addr] <= nu_q;
      finv_mem[wr_addr]  <= finv_q;
      gain_mem[wr_addr]  <= k_q;
      fact_mem[wr_addr]  <= l_q;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the scalar Kalman filter and disturbance smoother.
`timescale 1ns / 1ps
module tb_top;

  localparam longint SatMax   = 64'sd2147483647;
  localparam longint SatMin   = -64'sd2147483648;
  localparam int     Depth    = 1024;
  localparam int     StallMax = 20000;

  typedef struct {
    skc_pkg::word_t sig;
    skc_pkg::word_t svar;
    skc_pkg::word_t innov;
    skc_pkg::word_t inv;
    skc_pkg::word_t gain;
    skc_pkg::word_t fac;
    skc_pkg::word_t disturb;
    logic [9:0]     idx;
    logic           last;
    logic [1:0]     status;
  } smooth_res_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [skc_pkg::CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [skc_pkg::DataW-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          kind_i = skc_pkg::KIND_LOAD;
  logic signed [31:0]            observation_i = '0;
  logic signed [31:0]            noise_variance_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [31:0]            smoothed_signal_o, smoothed_variance_o, innovation_o;
  logic signed [31:0]            inverse_innovation_variance_o, filter_gain_o, state_factor_o;
  logic signed [31:0]            obs_disturbance_o;
  logic [9:0]                    time_index_o;
  logic                          last_o;
  logic [1:0]                    status_o;

  // Predictor state
  longint      reg_val [7];
  longint      pred_mean, pred_var, resid, resid_var;
  longint      obs_mem [Depth], nvar_mem [Depth], innov_mem [Depth];
  longint      inv_mem [Depth], gain_mem [Depth], fac_mem [Depth];
  int          step_count;
  bit          smoothing;
  smooth_res_t result_q [$];

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  scalar_kalman_disturbance_smoother_top DUT (.*);

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Saturating fixed-point arithmetic
  function automatic longint clamp(longint v);
    if (v > SatMax) return SatMax;
    if (v < SatMin) return SatMin;
    return v;
  endfunction

  function automatic longint from_mag(longint unsigned m, bit neg);
    if (m > 64'd2147483647) return neg ? SatMin : SatMax;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = (ma * mb + 64'd32768) >> 16;
    return from_mag(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_recip(longint f);
    longint unsigned d;
    if (f == 0) return SatMax;
    d = (f < 0) ? -f : f;
    return from_mag((64'd1 << 32) / d, f < 0);
  endfunction

  function automatic smooth_res_t reject(logic [1:0] st);
    smooth_res_t r;
    r = '{default: '0};
    r.status = st;
    return r;
  endfunction

  // Advance the predictor by one item and return the expected result
  function automatic smooth_res_t filter_step(bit kind, longint y, longint h);
    smooth_res_t r;
    longint z, t, a, p, nu, f, fi, k, l, n, d, u, eps;
    int idx;
    z = reg_val[skc_pkg::CFG_OBS_LOAD];
    t = reg_val[skc_pkg::CFG_TRANSITION];
    r = '{default: '0};
    if (kind == skc_pkg::KIND_LOAD) begin
      if (smoothing) return reject(skc_pkg::STATUS_BUSY);
      if (step_count >= Depth) return reject(skc_pkg::STATUS_FULL);
      if (step_count == 0) begin
        pred_mean = 0;
        pred_var  = reg_val[skc_pkg::CFG_INIT_VAR];
      end
      idx = step_count;
      a   = pred_mean;
      p   = pred_var;
      nu  = clamp(clamp(y - reg_val[skc_pkg::CFG_OBS_OFFSET]) - fx_mul(z, a));
      f   = clamp(fx_mul(fx_mul(z, z), p) + h);
      fi  = fx_recip(f);
      k   = fx_mul(fx_mul(fx_mul(t, p), z), fi);
      l   = clamp(t - fx_mul(k, z));
      pred_mean = clamp(clamp(reg_val[skc_pkg::CFG_INTERCEPT] + fx_mul(t, a))
                        + fx_mul(k, nu));
      pred_var  = clamp(clamp(fx_mul(fx_mul(t, t), p)
                        + fx_mul(fx_mul(reg_val[skc_pkg::CFG_NOISE_LOAD],
                                        reg_val[skc_pkg::CFG_NOISE_LOAD]),
                                 reg_val[skc_pkg::CFG_STATE_NVAR]))
                        - fx_mul(fx_mul(k, k), f));
      obs_mem[idx]  = y;
      nvar_mem[idx] = h;
      innov_mem[idx] = nu;
      inv_mem[idx]  = fi;
      gain_mem[idx] = k;
      fac_mem[idx]  = l;
      step_count    = idx + 1;
    end else begin
      if (step_count == 0) return reject(skc_pkg::STATUS_EMPTY);
      if (!smoothing) begin
        smoothing = 1'b1;
        resid     = 0;
        resid_var = 0;
      end
      idx = step_count - 1;
      nu  = innov_mem[idx];
      fi  = inv_mem[idx];
      k   = gain_mem[idx];
      l   = fac_mem[idx];
      n   = resid_var;
      d   = clamp(fi + fx_mul(fx_mul(k, n), k));
      r.svar = skc_pkg::word_t'(clamp(nvar_mem[idx]
                                      - fx_mul(fx_mul(nvar_mem[idx], d), nvar_mem[idx])));
      u   = clamp(fx_mul(nu, fi) - fx_mul(k, resid));
      eps = fx_mul(nvar_mem[idx], u);
      r.disturb = skc_pkg::word_t'(eps);
      r.sig     = skc_pkg::word_t'(clamp(obs_mem[idx] - eps));
      resid     = clamp(fx_mul(fx_mul(z, nu), fi) + fx_mul(l, resid));
      resid_var = clamp(fx_mul(fx_mul(z, z), fi) + fx_mul(fx_mul(l, n), l));
      step_count = idx;
      r.last = (idx == 0);
      if (idx == 0) smoothing = 1'b0;
    end
    r.innov = skc_pkg::word_t'(innov_mem[idx]);
    r.inv   = skc_pkg::word_t'(inv_mem[idx]);
    r.gain  = skc_pkg::word_t'(gain_mem[idx]);
    r.fac   = skc_pkg::word_t'(fac_mem[idx]);
    r.idx   = idx[9:0];
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin
    smooth_res_t e;
    if (out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = result_q.pop_front();
        if (smoothed_signal_o !== e.sig) report("smoothed_signal", smoothed_signal_o, e.sig);
        if (smoothed_variance_o !== e.svar)
          report("smoothed_variance", smoothed_variance_o, e.svar);
        if (innovation_o !== e.innov) report("innovation", innovation_o, e.innov);
        if (inverse_innovation_variance_o !== e.inv)
          report("inverse_innovation_variance", inverse_innovation_variance_o, e.inv);
        if (filter_gain_o !== e.gain) report("filter_gain", filter_gain_o, e.gain);
        if (state_factor_o !== e.fac) report("state_factor", state_factor_o, e.fac);
        if (obs_disturbance_o !== e.disturb)
          report("obs_disturbance", obs_disturbance_o, e.disturb);
        if (time_index_o !== e.idx) report("time_index", time_index_o, e.idx);
        if (last_o !== e.last) report("last", last_o, e.last);
        if (status_o !== e.status) report("status", status_o, e.status);
      end
    end
  end

  // Drive the result ready: long hold-off first, then random stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && result_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallMax) begin
      $display("scalar_kalman_disturbance_smoother_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word and predict it once accepted
  task automatic send_word(bit kind, longint y, longint h);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    observation_i    <= y[31:0];
    noise_variance_i <= h[31:0];
    do @(posedge clk_i); while (!in_ready_o);
    result_q.push_back(filter_step(kind, y, h));
  endtask

  // Drop valid and wait until every expected word has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [skc_pkg::CfgIdxW-1:0] idx, longint v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v[31:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_val[idx] = longint'(skc_pkg::word_t'(v[31:0]));
  endtask

  function automatic longint rand_word();
    return longint'(skc_pkg::word_t'($urandom));
  endfunction

  function automatic longint rand_obs();
    if ($urandom_range(7) == 0) return rand_word();
    return longint'($urandom_range(1 << 22)) - (1 << 21);
  endfunction

  function automatic longint rand_nvar();
    if ($urandom_range(9) == 0) return rand_word();
    return longint'($urandom_range(1 << 18, 1 << 12));
  endfunction

  // Moderate parameter draw, occasionally one register at full range
  task automatic draw_params();
    write_reg(skc_pkg::CFG_INIT_VAR,   $urandom_range(1 << 19, 1 << 12));
    write_reg(skc_pkg::CFG_OBS_OFFSET, longint'($urandom_range(1 << 18)) - (1 << 17));
    write_reg(skc_pkg::CFG_STATE_NVAR, $urandom_range(1 << 18, 1 << 10));
    write_reg(skc_pkg::CFG_TRANSITION, longint'($urandom_range(1 << 17)) - (1 << 16));
    write_reg(skc_pkg::CFG_INTERCEPT,  longint'($urandom_range(1 << 17)) - (1 << 16));
    write_reg(skc_pkg::CFG_NOISE_LOAD, longint'($urandom_range(1 << 18)) - (1 << 17));
    write_reg(skc_pkg::CFG_OBS_LOAD,   longint'($urandom_range(1 << 18)) - (1 << 17));
    if ($urandom_range(3) == 0) begin
      write_reg(skc_pkg::CfgIdxW'($urandom_range(6)), rand_word());
    end
  endtask

  // One series: loads, then smooths back to step zero, with some stray words
  task automatic run_series(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) send_word(skc_pkg::KIND_SMOOTH, rand_word(), rand_word());
      else send_word(skc_pkg::KIND_LOAD, rand_obs(), rand_nvar());
    end
    while (step_count != 0) begin
      if ($urandom_range(15) == 0) send_word(skc_pkg::KIND_LOAD, rand_obs(), rand_nvar());
      else send_word(skc_pkg::KIND_SMOOTH, rand_word(), rand_word());
    end
  endtask

  task automatic test_directed();
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    send_word(skc_pkg::KIND_LOAD, SatMax, SatMax);
    send_word(skc_pkg::KIND_LOAD, SatMin, SatMin);
    send_word(skc_pkg::KIND_LOAD, 0, 0);
    send_word(skc_pkg::KIND_LOAD, -1, 1);
    send_word(skc_pkg::KIND_SMOOTH, SatMax, SatMin);
    send_word(skc_pkg::KIND_LOAD, 65536, 65536);
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    // zero innovation variance: initial variance one plus noise minus one
    send_word(skc_pkg::KIND_LOAD, 131072, -65536);
    send_word(skc_pkg::KIND_LOAD, -131072, -65536);
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    drain();
  endtask

  task automatic test_reg_extremes();
    longint ext [3] = '{SatMax, SatMin, 0};
    for (int e = 0; e < 3; e++) begin
      for (int r = 0; r < 7; r++) write_reg(skc_pkg::CfgIdxW'(r), ext[e]);
      run_series(3);
      drain();
    end
  endtask

  task automatic test_random();
    int idle_set [4]  = '{0, 83, 0, 19};
    int stall_set [4] = '{0, 0, 83, 19};
    int sent;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      draw_params();
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      sent = 0;
      while (sent < 12) begin
        len = $urandom_range(4, 2);
        run_series(len);
        sent += 2 * len;
        if ($urandom_range(3) == 0) drain();
      end
      drain();
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // Hold the receiver off so the block backs up, then pause until empty
  task automatic test_backpressure();
    hold_left = 3000;
    for (int i = 0; i < 6; i++) send_word(skc_pkg::KIND_LOAD, rand_obs(), rand_nvar());
    drain();
    while (step_count != 0) send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    drain();
  endtask

  // Fill every step, overflow once, then smooth the newest steps
  task automatic test_full_store();
    write_reg(skc_pkg::CFG_TRANSITION, 32768);
    for (int i = 0; i < Depth; i++) begin
      send_word(skc_pkg::KIND_LOAD, rand_obs(), rand_nvar());
    end
    send_word(skc_pkg::KIND_LOAD, rand_obs(), rand_nvar());
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    send_word(skc_pkg::KIND_LOAD, rand_obs(), rand_nvar());
    send_word(skc_pkg::KIND_SMOOTH, 0, 0);
    drain();
  endtask

  initial begin
    reg_val = '{65536, 0, 65536, 65536, 0, 65536, 65536};
    pred_mean  = 0;
    pred_var   = 0;
    resid      = 0;
    resid_var  = 0;
    step_count = 0;
    smoothing  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reg_extremes();
    test_random();
    test_backpressure();
    test_full_store();
    if (errors == 0) begin
      $display("scalar_kalman_disturbance_smoother_top regression: pass");
    end else begin
      $display("scalar_kalman_disturbance_smoother_top regression: fail");
    end
    $finish;
  end

endmodule
